// ===== design/ikc_pkg.sv =====
// ikc_pkg: shared types and codes for the image kernel convolution block
// beat payloads, the front-to-back command, register and function codes
// no dependencies
package ikc_pkg;

  // fixed field widths of the channels
  localparam int FUNC_W   = 2;
  localparam int PIX_W    = 8;
  localparam int CIDX_W   = 10;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 10;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // command field widths, sized for the largest supported geometry
  localparam int CMD_COL_W  = 12;
  localparam int CMD_ROWM_W = 5;
  localparam int RAD_W      = 4;

  // function codes of an input beat
  localparam logic [FUNC_W-1:0] FN_COEF  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PIXEL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PIX_W-1:0]  pixel_in;
    logic [CIDX_W-1:0] coef_index;
    logic [COEF_W-1:0] coef_value;
  } ikc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic              frame_end;
  } ikc_out_t;

  // work handed from the front to the back
  typedef struct packed {
    logic                  do_coef;
    logic                  do_pix;
    logic                  emit;
    logic                  border;
    logic                  last;
    logic [CIDX_W-1:0]     coef_idx;
    logic [COEF_W-1:0]     coef_val;
    logic [PIX_W-1:0]      pix;
    logic [CMD_ROWM_W-1:0] wr_bank;
    logic [CMD_COL_W-1:0]  wr_col;
    logic [CMD_ROWM_W-1:0] rowm;
    logic [CMD_ROWM_W-1:0] base;
    logic [ROW_W-1:0]      oy;
    logic [CMD_COL_W-1:0]  ox;
    logic [RAD_W-1:0]      radius;
  } ikc_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BRD_RD,
    BK_BRD_WT,
    BK_SETUP,
    BK_RUN,
    BK_DRAIN
  } bk_state_t;

endpackage

// ===== design/ikc_ram.sv =====
// ikc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ikc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ikc_queue.sv =====
// ikc_queue: short command queue between the front and the back
// depends on ikc_pkg for the command type
module ikc_queue import ikc_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ikc_cmd_t din,
  output logic     full,
  input  logic     pop,
  output ikc_cmd_t dout,
  output logic     empty
);

  ikc_cmd_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/ikc_front.sv =====
// ikc_front: classifies input beats, tracks frame positions and issues commands
// depends on ikc_pkg for the beat and command types
module ikc_front import ikc_pkg::*; #(
  parameter int MAX_KERNEL = 27,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  ikc_in_t         item,
  input  logic            cfg_clear,
  input  logic [10:0]     cfg_width,
  input  logic [12:0]     cfg_height,
  input  logic [RAD_W-1:0] cfg_radius,
  output logic            push,
  output ikc_cmd_t        cmd
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int KM_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int PEND_W = $clog2(MAX_WIDTH * 4096 + 1);
  localparam int RMAX   = (MAX_KERNEL - 1) / 2;
  localparam int TAPS   = MAX_KERNEL * MAX_KERNEL;

  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [KM_W-1:0]   in_rowm_r, in_rowm_nxt;
  logic              in_done_r, in_done_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [KM_W-1:0]   out_rowm_r, out_rowm_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;

  logic [12:0]       w_c, h_c;
  logic [RAD_W-1:0]  r_c;
  logic [PEND_W-1:0] lag_c, pend_inc;
  logic              is_coef, is_pix, emit;
  logic              in_last_col, in_last_row, out_last_col, out_last_row, out_last;
  logic              border;
  logic [5:0]        base_c;

  // effective geometry, clamped to the supported range
  always_comb begin
    w_c = {2'b00, cfg_width};
    if (w_c == 13'd0) begin
      w_c = 13'd1;
    end else if (w_c > 13'(MAX_WIDTH)) begin
      w_c = 13'(MAX_WIDTH);
    end
    h_c = cfg_height;
    if (h_c == 13'd0) begin
      h_c = 13'd1;
    end else if (h_c > 13'd4096) begin
      h_c = 13'd4096;
    end
    r_c = (cfg_radius > RAD_W'(RMAX)) ? RAD_W'(RMAX) : cfg_radius;
  end

  // output lag in pixels: radius rows plus radius columns
  assign lag_c    = PEND_W'(r_c) * PEND_W'(w_c) + PEND_W'(r_c);
  assign pend_inc = pend_r + 1'b1;

  assign in_last_col  = (13'(in_col_r) == w_c - 13'd1);
  assign in_last_row  = (13'(in_row_r) == h_c - 13'd1);
  assign out_last_col = (13'(out_col_r) == w_c - 13'd1);
  assign out_last_row = (13'(out_row_r) == h_c - 13'd1);
  assign out_last     = out_last_col && out_last_row;

  // classify the beat
  always_comb begin
    is_coef = (item.func == FN_COEF) && (item.coef_index < CIDX_W'(TAPS));
    is_pix  = (item.func == FN_PIXEL) && !in_done_r;
    if (is_pix) begin
      emit = (pend_inc > lag_c);
    end else begin
      emit = (item.func == FN_FLUSH) && in_done_r;
    end
  end

  // pixels near any edge pass through
  assign border = (13'(out_row_r) < 13'(r_c)) || (13'(out_col_r) < 13'(r_c)) ||
                  (13'(out_row_r) + 13'(r_c) >= h_c) ||
                  (13'(out_col_r) + 13'(r_c) >= w_c);

  // line-store bank holding the top kernel row
  always_comb begin
    base_c = 6'(out_rowm_r) + 6'(MAX_KERNEL) - 6'(r_c);
    if (base_c >= 6'(MAX_KERNEL)) begin
      base_c = base_c - 6'(MAX_KERNEL);
    end
  end

  assign push = acc && (is_coef || is_pix || emit);

  always_comb begin
    cmd          = '0;
    cmd.do_coef  = is_coef;
    cmd.do_pix   = is_pix;
    cmd.emit     = emit;
    cmd.border   = border;
    cmd.last     = out_last;
    cmd.coef_idx = item.coef_index;
    cmd.coef_val = item.coef_value;
    cmd.pix      = item.pixel_in;
    cmd.wr_bank  = CMD_ROWM_W'(in_rowm_r);
    cmd.wr_col   = CMD_COL_W'(in_col_r);
    cmd.rowm     = CMD_ROWM_W'(out_rowm_r);
    cmd.base     = CMD_ROWM_W'(base_c);
    cmd.oy       = out_row_r;
    cmd.ox       = CMD_COL_W'(out_col_r);
    cmd.radius   = r_c;
  end

  // position counters
  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_rowm_nxt  = in_rowm_r;
    in_done_nxt  = in_done_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_rowm_nxt = out_rowm_r;
    pend_nxt     = pend_r;
    if (cfg_clear) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_rowm_nxt  = '0;
      in_done_nxt  = 1'b0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_rowm_nxt = '0;
      pend_nxt     = '0;
    end else if (acc) begin
      if (is_pix) begin
        if (in_last_col) begin
          in_col_nxt = '0;
          if (in_last_row) begin
            in_done_nxt = 1'b1;
          end else begin
            in_row_nxt  = in_row_r + 1'b1;
            in_rowm_nxt = (in_rowm_r == KM_W'(MAX_KERNEL - 1)) ? '0 : in_rowm_r + 1'b1;
          end
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
      end
      if (emit) begin
        if (out_last_col) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + 1'b1;
          out_rowm_nxt = (out_rowm_r == KM_W'(MAX_KERNEL - 1)) ? '0 : out_rowm_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
      if (is_pix && !emit) begin
        pend_nxt = pend_inc;
      end else if (emit && !is_pix) begin
        pend_nxt = pend_r - 1'b1;
      end
      // last pixel of the frame out: start over
      if (emit && out_last) begin
        in_col_nxt   = '0;
        in_row_nxt   = '0;
        in_rowm_nxt  = '0;
        in_done_nxt  = 1'b0;
        out_col_nxt  = '0;
        out_row_nxt  = '0;
        out_rowm_nxt = '0;
        pend_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_rowm_r  <= '0;
      in_done_r  <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_rowm_r <= '0;
      pend_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_rowm_r  <= in_rowm_nxt;
      in_done_r  <= in_done_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_rowm_r <= out_rowm_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

// ===== design/ikc_back.sv =====
// ikc_back: executes commands over banked line store and coefficient copies
// depends on ikc_pkg and ikc_ram; one kernel column of products per cycle
module ikc_back import ikc_pkg::*; #(
  parameter int MAX_KERNEL     = 27,
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  ikc_cmd_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output ikc_out_t out_data
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int KM_W     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int TAPS     = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SIDE_W   = $clog2(MAX_KERNEL + 1);
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL + 1);
  localparam int ACC_W    = PROD_W + $clog2(TAPS + 1);

  bk_state_t         state_r, state_nxt;
  ikc_cmd_t          cur_r;
  logic              v1_r, v2_r;
  logic              out_valid_r, out_valid_nxt;
  ikc_out_t          out_data_r;
  logic [SIDE_W-1:0] dx_r;
  logic [ACC_W-1:0]  acc_r;
  logic              tap_ok_r   [MAX_KERNEL];
  logic [TAP_W-1:0]  rowoff_r   [MAX_KERNEL];
  logic [PROD_W-1:0] prod_r     [MAX_KERNEL];

  logic              tap_ok_nxt [MAX_KERNEL];
  logic [TAP_W-1:0]  rowoff_nxt [MAX_KERNEL];
  logic [PIX_W-1:0]  line_rd    [MAX_KERNEL];
  logic [COEF_W-1:0] coef_rd    [MAX_KERNEL];

  logic              issue, load_brd, load_run;
  logic [SIDE_W-1:0] side_c;
  logic [12:0]       col_c;
  logic [COL_W-1:0]  line_raddr;
  logic [ROWSUM_W-1:0] rowsum;
  logic [ACC_W-1:0]  shf;
  logic [PIX_W-1:0]  sat_pix;

  assign side_c = SIDE_W'({cur_r.radius, 1'b1});

  // control sequence per command
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    load_brd  = 1'b0;
    load_run  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && !out_valid_r) begin
          q_pop = 1'b1;
          if (q_head.emit) begin
            state_nxt = q_head.border ? BK_BRD_RD : BK_SETUP;
          end
        end
      end
      BK_BRD_RD: begin
        state_nxt = BK_BRD_WT;
      end
      BK_BRD_WT: begin
        load_brd  = 1'b1;
        state_nxt = BK_IDLE;
      end
      BK_SETUP: begin
        state_nxt = BK_RUN;
      end
      BK_RUN: begin
        issue = 1'b1;
        if (dx_r == side_c - 1'b1) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!v1_r && !v2_r) begin
          load_run  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || load_brd || load_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-bank kernel row and tap offset for the current pixel
  always_comb begin
    logic [5:0]  t;
    logic [11:0] m;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      t = 6'(b) + 6'(MAX_KERNEL) - 6'(cur_r.base);
      if (t >= 6'(MAX_KERNEL)) begin
        t = t - 6'(MAX_KERNEL);
      end
      m             = 12'(t) * 12'(side_c);
      tap_ok_nxt[b] = (t < 6'(side_c));
      rowoff_nxt[b] = TAP_W'(m);
    end
  end

  // read column for the pass-through or the current kernel column
  assign col_c      = 13'(cur_r.ox) - 13'(cur_r.radius) + 13'(dx_r);
  assign line_raddr = (state_r == BK_BRD_RD) ? COL_W'(cur_r.ox) : COL_W'(col_c);

  // column sum of the registered products
  always_comb begin
    rowsum = '0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      rowsum = rowsum + ROWSUM_W'(prod_r[b]);
    end
  end

  // drop fraction bits and clip to the pixel range
  assign shf     = acc_r >> COEF_FRAC_BITS;
  assign sat_pix = (shf > ACC_W'(255)) ? 8'hFF : shf[PIX_W-1:0];

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (state_r == BK_SETUP) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        tap_ok_r[b] <= tap_ok_nxt[b];
        rowoff_r[b] <= rowoff_nxt[b];
      end
      dx_r  <= '0;
      acc_r <= '0;
    end else begin
      if (issue) begin
        dx_r <= dx_r + 1'b1;
      end
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(rowsum);
      end
    end
    if (v1_r) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        prod_r[b] <= tap_ok_r[b] ? PROD_W'(line_rd[b]) * PROD_W'(coef_rd[b]) : '0;
      end
    end
    if (load_brd || load_run) begin
      out_data_r.pixel_out <= load_brd ? line_rd[KM_W'(cur_r.rowm)] : sat_pix;
      out_data_r.out_row   <= cur_r.oy;
      out_data_r.out_col   <= cur_r.ox[OCOL_W-1:0];
      out_data_r.frame_end <= cur_r.last;
    end
  end

  // one line-store bank and one coefficient copy per kernel row
  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    ikc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (q_pop && q_head.do_pix && (q_head.wr_bank == CMD_ROWM_W'(b))),
      .waddr (COL_W'(q_head.wr_col)),
      .wdata (q_head.pix),
      .raddr (line_raddr),
      .rdata (line_rd[b])
    );
    ikc_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef (
      .clk   (clk),
      .we    (q_pop && q_head.do_coef),
      .waddr (TAP_W'(q_head.coef_idx)),
      .wdata (q_head.coef_val),
      .raddr (rowoff_r[b] + TAP_W'(dx_r)),
      .rdata (coef_rd[b])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/image_kernel_convolution.sv =====
// image_kernel_convolution: streaming 2-D kernel convolution of grayscale frames
// depends on ikc_pkg, ikc_front, ikc_queue, ikc_back, ikc_ram
//
//   channel   direction  ports                         beat
//   input     in         in_valid / in_ready           ikc_in_t (func, pixel, coef)
//   result    out        out_valid / out_ready         ikc_out_t (pixel, row, col, end)
//   config    in/out     cfg_psel .. cfg_pready (APB)  32-bit register write / read
//
// the front takes one beat per cycle while the command queue has room
// the back writes a coefficient or pixel as it pops the command, reads a pass-through
// pixel in BK_BRD_RD and BK_BRD_WT, and runs an interior pixel through BK_SETUP, BK_RUN
// and BK_DRAIN: one kernel column of 2r+1 products per cycle across the line-store banks
// the back starts a command only when the result register is empty
// synchronous active-low reset; the line store and coefficients hold no reset
module image_kernel_convolution import ikc_pkg::*; #(
  parameter int MAX_KERNEL     = 27,
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ikc_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ikc_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int QDEPTH = 4;

  logic [10:0]      width_r, width_nxt;
  logic [12:0]      height_r, height_nxt;
  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic             cfg_wr, cfg_clear;
  logic             in_acc, push, q_full, q_empty, q_pop;
  ikc_cmd_t         cmd, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    radius_nxt = radius_r;
    cfg_clear  = 1'b0;
    if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WIDTH: begin
          width_nxt = cfg_pwdata[10:0];
          cfg_clear = 1'b1;
        end
        REG_HEIGHT: begin
          height_nxt = cfg_pwdata[12:0];
          cfg_clear  = 1'b1;
        end
        REG_RADIUS: begin
          radius_nxt = cfg_pwdata[RAD_W-1:0];
          cfg_clear  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
      radius_r <= 4'd13;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      radius_r <= radius_nxt;
    end
  end

  // register reads
  always_comb begin
    case (cfg_paddr[3:2])
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      REG_RADIUS: cfg_prdata = CFG_DW'(radius_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign in_ready = !q_full;
  assign in_acc   = in_valid && in_ready;

  ikc_front #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .item       (in_data),
    .cfg_clear  (cfg_clear),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_radius (radius_r),
    .push       (push),
    .cmd        (cmd)
  );

  ikc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  ikc_back #(
    .MAX_KERNEL     (MAX_KERNEL),
    .MAX_WIDTH      (MAX_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/ikc_checker.sv =====
// ikc_checker: port-level checks for image_kernel_convolution, bound to the top
// depends on ikc_pkg
module ikc_checker import ikc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ikc_in_t           in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ikc_out_t          out_data,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata,
  input logic              cfg_pready
);

  // reset leaves no result beat pending
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // width written then read back
  a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == REG_WIDTH)
    ##1 (cfg_psel && !cfg_pwrite && cfg_paddr[3:2] == REG_WIDTH)
    |-> cfg_prdata == CFG_DW'($past(cfg_pwdata[10:0])))
    else $error("width readback mismatch");

  // radius written then read back
  a_radius_rb: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == REG_RADIUS)
    ##1 (cfg_psel && !cfg_pwrite && cfg_paddr[3:2] == REG_RADIUS)
    |-> cfg_prdata == CFG_DW'($past(cfg_pwdata[3:0])))
    else $error("radius readback mismatch");

endmodule

bind image_kernel_convolution ikc_checker u_ikc_checker (.*);
